// File: rtl/mqcf_pkg.sv
package mqcf_pkg;

  // block configuration
  localparam int DEPTH       = 8;
  localparam int QUEUES      = 4;
  localparam int VALUE_WIDTH = 32;

  // fixed field widths
  localparam int CMD_W      = 2;
  localparam int QIDX_W     = 2;
  localparam int IN_VALUE_W = 32;
  localparam int STATUS_W   = 2;
  localparam int DATA_W     = 32;

  // derived widths
  localparam int SLOT_W      = $clog2(DEPTH);
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int Q_W         = (QUEUES > 1) ? $clog2(QUEUES) : 1;
  localparam int STORE_DEPTH = QUEUES * DEPTH;
  localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_LIST   = 2'd2
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECODE,
    S_READ,
    S_EMIT
  } state_t;

  // request to the slot address unit
  typedef struct packed {
    logic [Q_W-1:0]    queue;
    logic [SLOT_W-1:0] head;
    logic [CNT_W-1:0]  offset;
  } addr_req_t;

  // slot within the queue and flat store address
  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [ADDR_W-1:0] addr;
  } addr_rsp_t;

endpackage

// File: rtl/mqcf_in_if.sv
interface mqcf_in_if;
  import mqcf_pkg::*;

  logic                         valid;
  logic                         ready;
  logic [CMD_W-1:0]             command;
  logic [QIDX_W-1:0]            queue_index;
  logic signed [IN_VALUE_W-1:0] value;

  modport source (output valid, command, queue_index, value, input ready);
  modport sink (input valid, command, queue_index, value, output ready);
endinterface

// File: rtl/mqcf_out_if.sv
interface mqcf_out_if;
  import mqcf_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [STATUS_W-1:0]      status;
  logic signed [DATA_W-1:0] data;
  logic                     last;

  modport source (output valid, status, data, last, input ready);
  modport sink (input valid, status, data, last, output ready);
endinterface

// File: rtl/multi_queue_circular_fifo.sv
// Bank of four circular queues sharing one store of QUEUES*DEPTH words.
// in_ch carries command, queue_index and value; out_ch carries status, data
// and last. Both are valid/ready channels; a word moves when both are high.
// Insert appends value (status full and dropped when the queue is full),
// remove pops the oldest word (status empty when none), list returns every
// held word oldest first without changing state. Each command returns one
// word, list returns one per held entry; the final one has last set.
// Command code three or an out-of-range queue is taken and ignored.
// A sequencer drives one slot address unit and one store read port.
// in_ch is ready only when idle. Insert goes from decode to emit. Remove,
// and list of a held queue, go from decode through a store read to emit;
// list then repeats the read and emit for each further word. Empty cases
// go from decode straight to emit.
// A stall on out_ch holds the result word and the sequencer in place.
// Reset empties all queues and returns the sequencer to idle; store words
// need no clearing since only held entries are read.
module multi_queue_circular_fifo (
  input logic       clk,
  input logic       rst,
  mqcf_in_if.sink   in_ch,
  mqcf_out_if.source out_ch
);
  import mqcf_pkg::*;

  state_t state;
  state_t state_next;

  logic [CMD_W-1:0]       cmd;
  logic [Q_W-1:0]         q;
  logic [VALUE_WIDTH-1:0] val;
  logic [CNT_W-1:0]       idx;

  logic [SLOT_W-1:0] head_slot [QUEUES];
  logic [CNT_W-1:0]  entry_count [QUEUES];

  status_t           out_status;
  logic [DATA_W-1:0] out_data;
  logic              out_last;

  logic [SLOT_W-1:0] head;
  logic [CNT_W-1:0]  cnt;
  logic              accept;
  logic              cmd_known;
  logic              is_full;
  logic              is_empty;

  addr_req_t req;
  addr_rsp_t rsp;
  logic [CNT_W-1:0] offset;

  logic                   ram_we;
  logic                   ram_re;
  logic [VALUE_WIDTH-1:0] ram_rdata;

  assign head     = head_slot[q];
  assign cnt      = entry_count[q];
  assign is_full  = (cnt == CNT_W'(DEPTH));
  assign is_empty = (cnt == '0);
  assign accept   = in_ch.valid && in_ch.ready;
  assign cmd_known = (in_ch.command == CMD_INSERT) || (in_ch.command == CMD_REMOVE) ||
                     (in_ch.command == CMD_LIST);

  // shared slot address unit
  assign req.queue  = q;
  assign req.head   = head;
  assign req.offset = offset;

  mqcf_addr u_addr (
    .req (req),
    .rsp (rsp)
  );

  mqcf_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (rsp.addr),
    .wdata (val),
    .re    (ram_re),
    .raddr (rsp.addr),
    .rdata (ram_rdata)
  );

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state, store strobes and address offset
  always_comb begin
    state_next   = state;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    offset       = '0;
    in_ch.ready  = 1'b0;
    out_ch.valid = 1'b0;
    case (state)
      S_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid && cmd_known && (int'(in_ch.queue_index) < QUEUES)) begin
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        case (cmd)
          CMD_INSERT: begin
            offset     = cnt;
            ram_we     = !is_full;
            state_next = S_EMIT;
          end
          CMD_REMOVE, CMD_LIST: begin
            ram_re     = !is_empty;
            state_next = is_empty ? S_EMIT : S_READ;
          end
          default: begin
            state_next = S_IDLE;
          end
        endcase
      end
      S_READ: begin
        // slot after head, used when a remove retires the head
        offset     = CNT_W'(1);
        state_next = S_EMIT;
      end
      S_EMIT: begin
        out_ch.valid = 1'b1;
        offset       = idx + CNT_W'(1);
        if (out_ch.ready) begin
          if ((cmd == CMD_LIST) && !out_last) begin
            ram_re     = 1'b1;
            state_next = S_READ;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // queue pointers and fill counts
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < QUEUES; i++) begin
        head_slot[i]   <= '0;
        entry_count[i] <= '0;
      end
    end else begin
      if (state == S_DECODE && cmd == CMD_INSERT && !is_full) begin
        entry_count[q] <= cnt + CNT_W'(1);
      end
      if (state == S_READ && cmd == CMD_REMOVE) begin
        head_slot[q]   <= rsp.slot;
        entry_count[q] <= cnt - CNT_W'(1);
      end
    end
  end

  // command latch, walk index and result word
  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else if (accept) begin
      cmd <= in_ch.command;
      q   <= Q_W'(in_ch.queue_index);
      val <= VALUE_WIDTH'($unsigned(in_ch.value));
      idx <= '0;
    end
    case (state)
      S_DECODE: begin
        out_data <= '0;
        out_last <= 1'b1;
        if (cmd == CMD_INSERT) begin
          out_status <= is_full ? ST_FULL : ST_OK;
        end else begin
          out_status <= is_empty ? ST_EMPTY : ST_OK;
        end
      end
      S_READ: begin
        out_status <= ST_OK;
        out_data   <= DATA_W'(ram_rdata);
        out_last   <= (cmd == CMD_REMOVE) || ((idx + CNT_W'(1)) == cnt);
      end
      S_EMIT: begin
        if (out_ch.ready && (cmd == CMD_LIST) && !out_last) begin
          idx <= idx + CNT_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  assign out_ch.status = out_status;
  assign out_ch.data   = out_data;
  assign out_ch.last   = out_last;

`ifndef SYNTH
  // a queue never holds more than its depth
  assert property (@(posedge clk) disable iff (rst) cnt <= CNT_W'(DEPTH))
    else $error("fill count above depth");

  // store is written only into a queue with room
  assert property (@(posedge clk) disable iff (rst) ram_we |-> !is_full)
    else $error("write into full queue");

  // input side is closed while a result word is offered
  assert property (@(posedge clk) disable iff (rst) !(in_ch.ready && out_ch.valid))
    else $error("input open while result pending");

  // final word of a command returns the block to idle
  assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.ready && out_ch.last) |=> in_ch.ready)
    else $error("not idle after final word");
`endif

endmodule

// File: rtl/mqcf_ram.sv
module mqcf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/mqcf_addr.sv
module mqcf_addr (
  input  mqcf_pkg::addr_req_t req,
  output mqcf_pkg::addr_rsp_t rsp
);
  import mqcf_pkg::*;

  logic [CNT_W:0] sum;
  logic [CNT_W:0] wrapped;

  // head plus offset stays below twice the depth, so one subtract wraps it
  assign sum     = (CNT_W + 1)'(req.head) + (CNT_W + 1)'(req.offset);
  assign wrapped = (sum >= (CNT_W + 1)'(DEPTH)) ? sum - (CNT_W + 1)'(DEPTH) : sum;

  // queue base plus slot
  assign rsp.slot = wrapped[SLOT_W-1:0];
  assign rsp.addr = ADDR_W'(req.queue) * ADDR_W'(DEPTH) + ADDR_W'(wrapped[SLOT_W-1:0]);

endmodule
